// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk_i, with and without reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Stepper sine profile package
// Constants, arcsine table and shared types of the step timing block.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned TablePoints = 100;
  localparam int unsigned MaxSteps    = 16384;
  localparam int unsigned IdxW        = $clog2(TablePoints);
  localparam int unsigned RemW        = $clog2(2 * (TablePoints - 1));
  localparam int unsigned ArgOne      = 1000000;
  localparam int unsigned ArgTwo      = 2000000;
  localparam int unsigned GridStep    = ArgOne / (TablePoints - 1);
  localparam int unsigned GridRem     = ArgOne % (TablePoints - 1);
  localparam int unsigned ArgScale    = 15625;
  localparam int unsigned ArgShift    = 7;
  localparam int unsigned HalfPiTicks = 131946891;
  localparam int unsigned PiTicks     = 263893782;
  localparam int unsigned MagW        = 27;

  localparam logic [1:0] CfgTotalAngle = 2'd0;
  localparam logic [1:0] CfgStepAngle  = 2'd1;
  localparam logic [1:0] CfgMoveTicks  = 2'd2;
  localparam logic [1:0] CfgStepCount  = 2'd3;

  localparam logic [MagW-1:0] AsinMag [TablePoints] = '{
            0,    848499,   1697085,   2545844,   3394863,
      4244229,   5094030,   5944354,   6795287,   7646921,
      8499343,   9352645,  10206917,  11062251,  11918740,
     12776479,  13635562,  14496087,  15358151,  16221854,
     17087298,  17954584,  18823819,  19695109,  20568563,
     21444293,  22322412,  23203036,  24086286,  24972283,
     25861152,  26753023,  27648027,  28546300,  29447982,
     30353218,  31262156,  32174950,  33091759,  34012746,
     34938082,  35867942,  36802510,  37741975,  38686535,
     39636394,  40591766,  41552875,  42519953,  43493243,
     44473000,  45459490,  46452994,  47453805,  48462232,
     49478601,  50503254,  51536554,  52578883,  53630649,
     54692281,  55764236,  56847003,  57941100,  59047082,
     60165544,  61297123,  62442504,  63602428,  64777691,
     65969160,  67177773,  68404555,  69650624,  70917207,
     72205657,  73517466,  74854290,  76217978,  77610601,
     79034491,  80492293,  81987026,  83522160,  85101718,
     86730410,  88413802,  90158563,  91972782,  93866446,
     95852119,  97945981, 100169480, 102552091, 105136281,
    107987272, 111214941, 115033700, 119997578, 131946891
  };

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MUL_P = 11'b000_0000_0010,
    S_CHK   = 11'b000_0000_0100,
    S_DIV_Q = 11'b000_0000_1000,
    S_ARG   = 11'b000_0001_0000,
    S_SRCH  = 11'b000_0010_0000,
    S_MUL_I = 11'b000_0100_0000,
    S_DIV_I = 11'b000_1000_0000,
    S_MUL_T = 11'b001_0000_0000,
    S_DIV_T = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_e;

endpackage

// ===== design/ssp_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring 64 by 32 bit unsigned divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssp_div import ssp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q, dvs_q;
  logic [63:0] quo_q;
  logic [32:0] part, diff;
  logic        ge;

  always_comb begin
    part = {rem_q, quo_q[63]};
    diff = part - {1'b0, dvs_q};
    ge   = (part >= {1'b0, dvs_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
      if (cnt_q == 6'd63) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : part[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== design/stepper_sine_profile_interval.sv =====
// ----------------------------------------------------------------------------
// Stepper sine profile interval
// Step time and timer reload of one step of a sinusoidal velocity move.
// ----------------------------------------------------------------------------
// One request evaluates the step time for k and for k+1, and each
// evaluation runs up to three passes of the shared serial divider plus a
// linear table search of one grid point per cycle, whose length is set by
// the profile argument. in_ready_o is high only between requests; a
// finished result waits in the output register.
module stepper_sine_profile_interval import ssp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [13:0]        step_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [30:0]        step_time_o,
  output logic signed [31:0] reload_value_o,
  output logic               last_step_o
);

  `include "assert_macros.svh"

  state_e state_q;
  logic   second_q, out_valid_q;

  logic [30:0] total_q, step_q, move_q;
  logic [14:0] count_q;

  logic [13:0]      k_q;
  logic [14:0]      kk_q;
  logic [45:0]      p_q;
  logic [20:0]      q_q;
  logic             neg_q;
  logic [19:0]      x_q, gx_q, dx_q;
  logic [RemW-1:0]  rem_q;
  logic [IdxW-1:0]  i_q;
  logic [27:0]      vplus_q;
  logic [30:0]      t0_q, t1_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic [RemW-1:0] remsum;
  logic            carry;
  logic [19:0]     gnext;
  logic            more;
  logic            skip;
  logic [MagW-1:0] m0, m1;
  logic [27:0]     mag;

  ssp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    remsum = rem_q + RemW'(GridRem);
    carry  = (remsum >= RemW'(TablePoints - 1));
    gnext  = gx_q + 20'(GridStep) + {19'd0, carry};
    more   = (i_q < IdxW'(TablePoints - 2)) && (x_q > gnext);
    skip   = (total_q == '0) || (p_q >= {15'd0, total_q});
    m0     = AsinMag[i_q];
    m1     = AsinMag[IdxW'(i_q + 1'b1)];
    mag    = {1'b0, m0} + div_rsp.quotient[27:0];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MUL_P: begin
        mul_a = {17'd0, kk_q};
        mul_b = {1'b0, step_q};
      end
      S_CHK: begin
        mul_a = 32'(ArgScale);
        mul_b = {1'b0, p_q[30:0]};
      end
      S_MUL_I: begin
        mul_a = 32'(m1 - m0);
        mul_b = {12'd0, x_q - gx_q};
      end
      S_MUL_T: begin
        mul_a = {4'd0, vplus_q};
        mul_b = {1'b0, move_q};
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = prod;
    div_req.divisor  = '0;
    case (state_q)
      S_CHK: begin
        div_req.start    = !skip;
        div_req.dividend = {prod[63-ArgShift:0], ArgShift'(0)};
        div_req.divisor  = {1'b0, total_q};
      end
      S_MUL_I: begin
        div_req.start   = 1'b1;
        div_req.divisor = {12'd0, dx_q};
      end
      S_MUL_T: begin
        div_req.start   = 1'b1;
        div_req.divisor = 32'(PiTicks);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 31'd12566370;
      step_q  <= 31'd3926;
      move_q  <= 31'd42000000;
      count_q <= 15'd3200;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgTotalAngle: total_q <= cfg_wdata_i;
        CfgStepAngle:  step_q  <= cfg_wdata_i;
        CfgMoveTicks:  move_q  <= cfg_wdata_i;
        CfgStepCount:  count_q <= cfg_wdata_i[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE:  if (in_valid_i) begin
          state_q  <= S_MUL_P;
          second_q <= 1'b0;
        end
        S_MUL_P: state_q <= S_CHK;
        S_CHK:   state_q <= skip ? S_ARG : S_DIV_Q;
        S_DIV_Q: if (div_rsp.done) state_q <= S_ARG;
        S_ARG:   state_q <= S_SRCH;
        S_SRCH:  if (!more) state_q <= S_MUL_I;
        S_MUL_I: state_q <= S_DIV_I;
        S_DIV_I: if (div_rsp.done) state_q <= S_MUL_T;
        S_MUL_T: state_q <= S_DIV_T;
        S_DIV_T: if (div_rsp.done) begin
          state_q  <= second_q ? S_DONE : S_MUL_P;
          second_q <= 1'b1;
        end
        S_DONE:  if (!out_valid_q || out_ready_i) begin
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        k_q  <= step_index_i;
        kk_q <= {1'b0, step_index_i};
      end
      S_MUL_P: p_q <= prod[45:0];
      S_CHK:   if (skip) q_q <= 21'(ArgTwo);
      S_DIV_Q: if (div_rsp.done) q_q <= div_rsp.quotient[20:0];
      S_ARG: begin
        neg_q <= (q_q > 21'(ArgOne));
        x_q   <= (q_q > 21'(ArgOne)) ? 20'(q_q - 21'(ArgOne)) : 20'(21'(ArgOne) - q_q);
        gx_q  <= '0;
        rem_q <= '0;
        i_q   <= '0;
      end
      S_SRCH: begin
        if (more) begin
          i_q   <= IdxW'(i_q + 1'b1);
          gx_q  <= gnext;
          rem_q <= carry ? RemW'(remsum - RemW'(TablePoints - 1)) : remsum;
        end else begin
          dx_q <= gnext - gx_q;
        end
      end
      S_DIV_I: if (div_rsp.done) begin
        vplus_q <= neg_q ? 28'(HalfPiTicks) + mag : 28'(HalfPiTicks) - mag;
      end
      S_DIV_T: if (div_rsp.done) begin
        if (second_q) t1_q <= div_rsp.quotient[30:0];
        else begin
          t0_q <= div_rsp.quotient[30:0];
          kk_q <= 15'(kk_q + 1'b1);
        end
      end
      S_DONE: if (!out_valid_q || out_ready_i) begin
        step_time_o    <= t0_q;
        reload_value_o <= signed'({1'b0, t1_q} - {1'b0, t0_q} - 32'd1);
        last_step_o    <= (15'({1'b0, k_q} + 15'd1) == count_q);
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `ASSERT_RST(a_div_done_wait, div_rsp.done |-> (state_q == S_DIV_Q || state_q == S_DIV_I || state_q == S_DIV_T), "divider finished outside a wait state")
  `ASSERT_RST(a_accept_start, in_valid_i && in_ready_o |=> state_q == S_MUL_P && !second_q, "accepted request did not start first evaluation")
  `ASSERT_RST(a_search_bound, state_q == S_SRCH |-> i_q <= IdxW'(TablePoints - 2), "table search ran past the last segment")
  `ASSERT_ALWAYS(a_idle_div, in_ready_o |-> !div_rsp.busy, "divider busy while idle")

endmodule
